### rtl/bnfl_pkg.sv
package bnfl_pkg;

    // default list depth
    localparam int MAX_ENTRIES_DEF = 16;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [33:0] key_time;
        logic [15:0] entry_tag;
        logic        is_private;
        logic        is_owned;
        logic [3:0]  read_slot;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  insert_slot;
        logic [4:0]  entry_count;
        logic        slot_valid;
        logic [33:0] slot_time;
        logic [15:0] slot_tag;
        logic        slot_private;
        logic        slot_owned;
    } t_res;

    // one stored list entry
    typedef struct packed {
        logic [33:0] key_time;
        logic [15:0] entry_tag;
        logic        is_private;
        logic        is_owned;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_READ
    } t_state;

endpackage

### rtl/bounded_newest_first_list_unit.sv
// an insert scans upwards from the last held entry and places the new one, an empty list
//   needs no scan; a read fetches one slot; a clear or an unknown request answers without
//   raising busy, else busy falls in the cycle the result appears; nothing is taken while
//   busy; the entry memory's single write port moves each older entry down, one a cycle
// reset: synchronous active low, empties the list and idles the sequencer; the entry
//   memory is not cleared; results are one-cycle strobes, the receiver cannot stall
module bounded_newest_first_list_unit #(
    parameter int MAX_ENTRIES = bnfl_pkg::MAX_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bnfl_pkg::t_req  i_req,
    output logic            o_done,
    output bnfl_pkg::t_res  o_res
);

    // address width of the entry memory and width of a count of 0..MAX_ENTRIES
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    // common width for comparing the 4-bit slot number against the count
    localparam int SW = (CW > 4) ? CW : 4;

    // entry memory, newest entry in slot 0
    bnfl_pkg::t_entry mem_entries [MAX_ENTRIES];

    bnfl_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_pos, n_pos;
    bnfl_pkg::t_req   r_req, n_req;
    bnfl_pkg::t_entry r_rd_data;
    bnfl_pkg::t_res   r_res, n_res;
    logic             r_done, n_done;

    // memory port controls
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    bnfl_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic             accept;
    logic             scan_older;
    logic             scan_at_end;
    bnfl_pkg::t_entry new_entry;
    logic [CW-1:0]    count_after_ins;

    assign accept = start && (r_state == bnfl_pkg::ST_IDLE);
    assign busy   = (r_state != bnfl_pkg::ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    // entry under test is older than the new one: it moves down a slot
    assign scan_older  = (r_rd_data.key_time < r_req.key_time);
    // the entry under test sits in the top slot of the list
    assign scan_at_end = (r_pos == CW'(1));

    assign new_entry.key_time   = r_req.key_time;
    assign new_entry.entry_tag  = r_req.entry_tag;
    assign new_entry.is_private = r_req.is_private;
    assign new_entry.is_owned   = r_req.is_owned;

    // a full list stays full, the last entry falls off
    assign count_after_ins = (r_count < CW'(MAX_ENTRIES)) ? (r_count + CW'(1)) : r_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bnfl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == bnfl_pkg::REQ_INSERT) begin
                        n_state = (r_count == '0) ? bnfl_pkg::ST_PLACE : bnfl_pkg::ST_SCAN;
                    end else if (i_req.req_type == bnfl_pkg::REQ_READ) begin
                        n_state = bnfl_pkg::ST_READ;
                    end
                end
            end
            bnfl_pkg::ST_SCAN: begin
                if (scan_older) begin
                    if (scan_at_end) begin
                        n_state = bnfl_pkg::ST_PLACE;
                    end
                end else begin
                    n_state = bnfl_pkg::ST_IDLE;
                end
            end
            bnfl_pkg::ST_PLACE: begin
                n_state = bnfl_pkg::ST_IDLE;
            end
            bnfl_pkg::ST_READ: begin
                n_state = bnfl_pkg::ST_IDLE;
            end
            default: begin
                n_state = bnfl_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, memory port and result
    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_req     = r_req;
        n_res     = r_res;
        n_done    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_rd_data;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            bnfl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    n_pos = r_count;
                    if (i_req.req_type == bnfl_pkg::REQ_INSERT) begin
                        // fetch the last held entry, the scan walks upwards from there
                        mem_re    = (r_count != '0);
                        mem_raddr = AW'(r_count - CW'(1));
                    end else if (i_req.req_type == bnfl_pkg::REQ_READ) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(i_req.read_slot);
                    end else begin
                        // clear, or an unknown code that only reports the count
                        if (i_req.req_type == bnfl_pkg::REQ_CLEAR) begin
                            n_count = '0;
                        end
                        n_res             = '0;
                        n_res.entry_count = (i_req.req_type == bnfl_pkg::REQ_CLEAR) ?
                                            5'd0 : 5'(r_count);
                        n_done            = 1'b1;
                    end
                end
            end
            bnfl_pkg::ST_SCAN: begin
                if (scan_older) begin
                    // shift down one slot; beyond the last slot it is dropped
                    mem_we    = (r_pos < CW'(MAX_ENTRIES));
                    mem_waddr = AW'(r_pos);
                    mem_wdata = r_rd_data;
                    n_pos     = r_pos - CW'(1);
                    // prefetch the next entry up while this one is written
                    mem_re    = !scan_at_end;
                    mem_raddr = AW'(r_pos - CW'(2));
                end else begin
                    n_res  = '0;
                    n_done = 1'b1;
                    if (r_pos < CW'(MAX_ENTRIES)) begin
                        mem_we            = 1'b1;
                        mem_waddr         = AW'(r_pos);
                        mem_wdata         = new_entry;
                        n_count           = count_after_ins;
                        n_res.accepted    = 1'b1;
                        n_res.insert_slot = 4'(r_pos);
                        n_res.entry_count = 5'(count_after_ins);
                    end else begin
                        // no newer than a full list: dropped
                        n_res.entry_count = 5'(r_count);
                    end
                end
            end
            bnfl_pkg::ST_PLACE: begin
                mem_we            = 1'b1;
                mem_waddr         = AW'(r_pos);
                mem_wdata         = new_entry;
                n_count           = count_after_ins;
                n_res             = '0;
                n_res.accepted    = 1'b1;
                n_res.insert_slot = 4'(r_pos);
                n_res.entry_count = 5'(count_after_ins);
                n_done            = 1'b1;
            end
            bnfl_pkg::ST_READ: begin
                n_res             = '0;
                n_res.entry_count = 5'(r_count);
                if (SW'(r_req.read_slot) < SW'(r_count)) begin
                    n_res.slot_valid   = 1'b1;
                    n_res.slot_time    = r_rd_data.key_time;
                    n_res.slot_tag     = r_rd_data.entry_tag;
                    n_res.slot_private = r_rd_data.is_private;
                    n_res.slot_owned   = r_rd_data.is_owned;
                end
                n_done = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bnfl_pkg::ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_req <= n_req;
        r_res <= n_res;
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_entries[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem_entries[mem_raddr];
        end
    end

endmodule

### verif/bounded_newest_first_list_unit_tb.sv
`timescale 1ns / 1ps

module bounded_newest_first_list_unit_tb;

    import bnfl_pkg::*;

    localparam int DEPTH = MAX_ENTRIES_DEF;
    // request code the block leaves unused, it only reports the count back
    localparam logic [1:0] REQ_NONE = 2'd3;
    // quiet cycles tolerated before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    localparam int TARGET_REQUESTS = 1800;
    // stretch of the run with no random idle gaps from the sender
    localparam int BUSY_STRETCH_LO = 600;
    localparam int BUSY_STRETCH_HI = 1000;
    // point at which the sender waits for every reply to come back
    localparam int DRAIN_POINT = 900;

    // tracks the expected list contents and the replies still owed
    class list_tracker;
        t_entry slots [DEPTH];
        int     held;
        t_res   awaited [$];
        int     failures;

        function new();
            held     = 0;
            failures = 0;
        endfunction

        // work out the reply of one request and move the tracked list along
        function t_res predict(t_req r);
            t_res e;
            int   pos;
            int   last;
            int   i;
            e = '0;
            case (r.req_type)
                REQ_INSERT: begin
                    // land after every entry that is not older, so ties keep arrival order
                    pos = held;
                    while (pos > 0 && slots[pos-1].key_time < r.key_time) pos--;
                    if (pos < DEPTH) begin
                        // a full list loses its last entry
                        last = (held < DEPTH) ? held : DEPTH - 1;
                        for (i = last; i > pos; i--) slots[i] = slots[i-1];
                        slots[pos].key_time   = r.key_time;
                        slots[pos].entry_tag  = r.entry_tag;
                        slots[pos].is_private = r.is_private;
                        slots[pos].is_owned   = r.is_owned;
                        if (held < DEPTH) held++;
                        e.accepted    = 1'b1;
                        e.insert_slot = 4'(pos);
                    end
                end
                REQ_READ: begin
                    if (int'(r.read_slot) < held) begin
                        e.slot_valid   = 1'b1;
                        e.slot_time    = slots[r.read_slot].key_time;
                        e.slot_tag     = slots[r.read_slot].entry_tag;
                        e.slot_private = slots[r.read_slot].is_private;
                        e.slot_owned   = slots[r.read_slot].is_owned;
                    end
                end
                REQ_CLEAR: held = 0;
                default: ;
            endcase
            e.entry_count = 5'(held);
            return e;
        endfunction

        function void take_request(t_req r);
            awaited.push_back(predict(r));
        endfunction

        function void compare_field(string name, logic [33:0] want, logic [33:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void match_reply(t_res got);
            t_res want;
            if (awaited.size() == 0) begin
                $error("reply with no request outstanding: %p", got);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("insert_slot", want.insert_slot, got.insert_slot);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("slot_valid", want.slot_valid, got.slot_valid);
            compare_field("slot_time", want.slot_time, got.slot_time);
            compare_field("slot_tag", want.slot_tag, got.slot_tag);
            compare_field("slot_private", want.slot_private, got.slot_private);
            compare_field("slot_owned", want.slot_owned, got.slot_owned);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_done;
    t_res o_res;

    list_tracker book;
    bit          req_fire;
    int          quiet_cycles;
    int          requests_sent;
    bit          allow_idle;

    bounded_newest_first_list_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #2 i_clk = ~i_clk;

    // monitor: everything is sampled at the rising edge, the driver moves on the falling one
    always @(posedge i_clk) begin
        req_fire = 1'b0;
        if (i_rst_n) begin
            if ($isunknown({o_done, busy})) begin
                $error("handshake outputs unknown: o_done %b busy %b", o_done, busy);
                book.failures++;
            end
            // a reply never belongs to the request taken at the same edge,
            // so it is matched before that request is booked
            if (o_done === 1'b1) book.match_reply(o_res);
            if (start && busy === 1'b0) begin
                book.take_request(i_req);
                req_fire = 1'b1;
            end
            if (o_done === 1'b1 || req_fire) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // request with every field random, used for noise and for filler
    function automatic t_req rand_req();
        t_req q;
        q.req_type   = 2'($urandom_range(3));
        q.key_time   = {2'($urandom_range(3)), 32'($urandom())};
        q.entry_tag  = 16'($urandom_range(65535));
        q.is_private = 1'($urandom_range(1));
        q.is_owned   = 1'($urandom_range(1));
        q.read_slot  = 4'($urandom_range(15));
        return q;
    endfunction

    function automatic t_req insert_req(logic [33:0] t);
        t_req q;
        q          = rand_req();
        q.req_type = REQ_INSERT;
        q.key_time = t;
        return q;
    endfunction

    function automatic t_req read_req(logic [3:0] slot);
        t_req q;
        q           = rand_req();
        q.req_type  = REQ_READ;
        q.read_slot = slot;
        return q;
    endfunction

    function automatic t_req plain_req(logic [1:0] code);
        t_req q;
        q          = rand_req();
        q.req_type = code;
        return q;
    endfunction

    // hand one request over, maybe after a short idle gap with junk on the bus;
    // start stays high afterwards so back-to-back requests need no gap
    task automatic issue(input t_req r);
        if (allow_idle && $urandom_range(99) < 19) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) begin
                i_req = rand_req();
                @(negedge i_clk);
            end
        end
        start = 1'b1;
        i_req = r;
        do @(negedge i_clk); while (!req_fire);
        if (r.req_type != REQ_NONE) requests_sent++;
    endtask

    // hold off until every reply owed has come back
    task automatic drain();
        start = 1'b0;
        while (book.awaited.size() != 0) @(negedge i_clk);
    endtask

    // one batch as the caller uses the list: clear, then inserts and reads
    task automatic run_batch();
        int          n;
        int          mode;
        int          pick;
        int          s;
        logic [33:0] t;
        issue(plain_req(REQ_CLEAR));
        n    = $urandom_range(1, 24);
        mode = $urandom_range(3);
        t    = {2'($urandom_range(3)), 32'($urandom())};
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                case (mode)
                    0: t = 34'($urandom_range(7));        // crowded times, ties and drops
                    1: t = t + 34'($urandom_range(2));    // newer and newer, tail falls off
                    2: t = t - 34'($urandom_range(2));    // older and older, full list drops
                    default: t = {2'($urandom_range(3)), 32'($urandom())};
                endcase
                issue(insert_req(t));
            end else if (pick < 95) begin
                issue(read_req(4'($urandom_range(15))));
            end else begin
                issue(plain_req(REQ_NONE));
            end
        end
        // sometimes walk every slot to check the whole list
        if ($urandom_range(99) < 40) begin
            for (s = 0; s < DEPTH; s++) issue(read_req(4'(s)));
        end
    endtask

    initial begin
        book          = new();
        quiet_cycles  = 0;
        requests_sent = 0;
        allow_idle    = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: empty list, unused code, extreme fields, ties
        issue(read_req(4'd0));
        issue(read_req(4'd15));
        issue(plain_req(REQ_CLEAR));
        issue(plain_req(REQ_NONE));
        begin
            t_req q;
            q            = insert_req({34{1'b1}});
            q.entry_tag  = 16'hFFFF;
            q.is_private = 1'b1;
            q.is_owned   = 1'b1;
            issue(q);
            q            = insert_req('0);
            q.entry_tag  = '0;
            q.is_private = 1'b0;
            q.is_owned   = 1'b0;
            issue(q);
        end
        issue(insert_req({34{1'b1}}));    // tie with the newest, lands behind it
        issue(insert_req(34'd1));         // between the newest pair and the unknown time
        issue(read_req(4'd0));
        issue(read_req(4'd1));
        issue(read_req(4'd2));
        issue(read_req(4'd3));
        issue(read_req(4'd4));            // just past the count
        issue(read_req(4'd15));
        issue(plain_req(REQ_NONE));
        issue(plain_req(REQ_CLEAR));
        issue(read_req(4'd0));            // stale slot after clear reads as empty
        issue(insert_req('0));
        issue(insert_req('0));            // equal unknown times keep arrival order
        issue(read_req(4'd1));

        // random part: mostly well-formed batches, some raw noise
        while (requests_sent < TARGET_REQUESTS) begin
            allow_idle = !(requests_sent >= BUSY_STRETCH_LO && requests_sent < BUSY_STRETCH_HI);
            if (requests_sent >= DRAIN_POINT && requests_sent < DRAIN_POINT + 40) begin
                drain();
                requests_sent = DRAIN_POINT + 40;
            end
            if ($urandom_range(99) < 85) run_batch();
            else repeat ($urandom_range(1, 8)) issue(rand_req());
        end

        drain();
        repeat (DEPTH + 4) @(negedge i_clk);
        if (book.failures == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
